FILE: hw/rtl/dlvc_pkg.sv
package dlvc_pkg;

   // Table sizes.
   localparam int SLOT_COUNT  = 1024;
   localparam int COLOR_COUNT = 1024;

   // Field widths on the streams.
   localparam int SLOT_FIELD_W  = 10;
   localparam int COLOR_FIELD_W = 10;
   localparam int DIST_FIELD_W  = 11;

   // Field positions inside req_tdata, lowest first.
   localparam int SLOT_LSB  = 0;
   localparam int COLOR_LSB = SLOT_LSB + SLOT_FIELD_W;

   localparam int REQ_DATA_W = ((SLOT_FIELD_W + COLOR_FIELD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((DIST_FIELD_W + 7) / 8) * 8;

   // Internal widths derived from the table sizes.
   localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int COLOR_W = (COLOR_COUNT > 1) ? $clog2(COLOR_COUNT) : 1;
   // A histogram entry counts up to SLOT_COUNT slots.
   localparam int HIST_W  = $clog2(SLOT_COUNT + 1);
   // Color zero is never counted, so the total stays below COLOR_COUNT.
   localparam int TOTAL_W = (COLOR_COUNT > 1) ? $clog2(COLOR_COUNT) : 1;

   // Clearing pass after reset covers the larger table.
   localparam int CLEAR_LEN = (SLOT_COUNT > COLOR_COUNT) ? SLOT_COUNT : COLOR_COUNT;
   localparam int CLR_W     = $clog2(CLEAR_LEN);

   // Result queue; depth is a power of two so the pointers wrap on their own.
   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int CREDIT_W       = $clog2(RSP_FIFO_DEPTH + 1);

   // One pipeline stage of the update path.
   typedef struct packed {
      logic               valid;
      logic               active;
      logic [COLOR_W-1:0] new_color;
   } stage_type;

   // Write port of a histogram RAM, also registered for forwarding.
   typedef struct packed {
      logic               en;
      logic [COLOR_W-1:0] addr;
      logic [HIST_W-1:0]  data;
   } hist_wr_type;

endpackage

FILE: hw/rtl/dlvc_ram.sv
module dlvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hw/rtl/distinct_label_value_counter_top.sv
// Keeps a color for each slot and reports, for every request, how many distinct
// nonzero colors the slots hold after that request's update. A request
// carries a slot and its new color; color zero uncolors the slot, and a slot or
// color beyond the table sizes leaves the state alone and reports the current
// total. One request is taken per clock cycle while req_tready is high, and
// each gives exactly one result, which passes through s1_ff and s2_ff into the
// result queue. The update runs in a three-stage pipeline (slot table read,
// two histogram reads, histogram write) with forwarding of the last write, and
// a four-entry result queue parts the two sides; outside the clearing pass,
// req_tready drops only when four results are in flight or waiting. After
// reset a clearing pass zeroes all tables, one entry per cycle for the larger
// of the slot and color counts; req_tready stays low until it is done.
module distinct_label_value_counter_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // Fields from bit 0: slot_index[9:0], color_value[19:10], zero fill.
   input  logic [dlvc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // Fields from bit 0: distinct_colors[10:0], zero fill.
   output logic [dlvc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import dlvc_pkg::*;

   logic                      req_acc;
   logic                      rsp_acc;
   logic [SLOT_FIELD_W-1:0]   req_slot;
   logic [COLOR_FIELD_W-1:0]  req_color;
   logic                      req_active;

   // Clearing pass.
   logic                      clearing_ff, clearing_in;
   logic [CLR_W-1:0]          clr_cnt_ff, clr_cnt_in;

   // Pipeline stages.
   stage_type                 s1_ff, s1_in;
   stage_type                 s2_ff, s2_in;
   logic [COLOR_W-1:0]        s2_old_ff, s2_old_in;

   // Slot table port.
   logic                      slot_wr_en;
   logic [SLOT_W-1:0]         slot_wr_addr;
   logic [COLOR_W-1:0]        slot_wr_data;
   logic [SLOT_W-1:0]         slot_rd_addr;
   logic [COLOR_W-1:0]        slot_rd_data;

   // Histogram as two running counts per color: additions and removals.
   hist_wr_type               inc_wr, dec_wr;
   hist_wr_type               inc_fw_ff, dec_fw_ff;
   logic [HIST_W-1:0]         inc_old_rd, inc_new_rd, dec_old_rd, dec_new_rd;
   logic [HIST_W-1:0]         inc_old, inc_new, dec_old, dec_new;
   logic [HIST_W-1:0]         hist_old, hist_new, hist_new_mid;
   logic                      dec_en, inc_en, drop, rise;

   logic [TOTAL_W-1:0]        total_ff, total_in;

   // Result queue and credit.
   logic [DIST_FIELD_W-1:0]   fifo_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CREDIT_W-1:0]       fifo_count_ff, fifo_count_in;
   logic [CREDIT_W-1:0]       credit_ff, credit_in;

   assign req_tready = !clearing_ff && (credit_ff < CREDIT_W'(RSP_FIFO_DEPTH));
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = (fifo_count_ff != '0);
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = RSP_DATA_W'(fifo_ff[rd_ptr_ff]);

   assign req_slot   = req_tdata[SLOT_LSB +: SLOT_FIELD_W];
   assign req_color  = req_tdata[COLOR_LSB +: COLOR_FIELD_W];
   assign req_active = (32'(req_slot) < SLOT_COUNT) && (32'(req_color) < COLOR_COUNT);

   // Clearing pass control.
   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + CLR_W'(1);
         if (32'(clr_cnt_ff) == CLEAR_LEN - 1) begin
            clearing_in = 1'b0;
         end
      end
   end

   // Stage 0: the slot table is read and rewritten in the same cycle, so the
   // old color comes out while the new one goes in.
   always_comb begin
      slot_rd_addr = SLOT_W'(req_slot);
      if (clearing_ff) begin
         slot_wr_en   = (32'(clr_cnt_ff) < SLOT_COUNT);
         slot_wr_addr = clr_cnt_ff[SLOT_W-1:0];
         slot_wr_data = '0;
      end else begin
         slot_wr_en   = req_acc && req_active;
         slot_wr_addr = SLOT_W'(req_slot);
         slot_wr_data = COLOR_W'(req_color);
      end
   end

   dlvc_ram #(.WIDTH(COLOR_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   always_comb begin
      s1_in.valid     = req_acc;
      s1_in.active    = req_acc && req_active;
      s1_in.new_color = COLOR_W'(req_color);
      s2_in           = s1_ff;
      s2_old_in       = slot_rd_data;
   end

   // Stage 1 reads both counts at the old and at the new color; each RAM has a
   // twin so that two addresses can be read in the same cycle.
   dlvc_ram #(.WIDTH(HIST_W), .DEPTH(COLOR_COUNT)) u_inc_old_ram (
      .clock   (clock),
      .wr_en   (inc_wr.en),
      .wr_addr (inc_wr.addr),
      .wr_data (inc_wr.data),
      .rd_addr (slot_rd_data),
      .rd_data (inc_old_rd)
   );

   dlvc_ram #(.WIDTH(HIST_W), .DEPTH(COLOR_COUNT)) u_inc_new_ram (
      .clock   (clock),
      .wr_en   (inc_wr.en),
      .wr_addr (inc_wr.addr),
      .wr_data (inc_wr.data),
      .rd_addr (s1_ff.new_color),
      .rd_data (inc_new_rd)
   );

   dlvc_ram #(.WIDTH(HIST_W), .DEPTH(COLOR_COUNT)) u_dec_old_ram (
      .clock   (clock),
      .wr_en   (dec_wr.en),
      .wr_addr (dec_wr.addr),
      .wr_data (dec_wr.data),
      .rd_addr (slot_rd_data),
      .rd_data (dec_old_rd)
   );

   dlvc_ram #(.WIDTH(HIST_W), .DEPTH(COLOR_COUNT)) u_dec_new_ram (
      .clock   (clock),
      .wr_en   (dec_wr.en),
      .wr_addr (dec_wr.addr),
      .wr_data (dec_wr.data),
      .rd_addr (s1_ff.new_color),
      .rd_data (dec_new_rd)
   );

   // Stage 2: the read missed only the write made in the previous cycle, which
   // the forwarding registers still hold.
   always_comb begin
      inc_old = (inc_fw_ff.en && inc_fw_ff.addr == s2_old_ff) ? inc_fw_ff.data : inc_old_rd;
      dec_old = (dec_fw_ff.en && dec_fw_ff.addr == s2_old_ff) ? dec_fw_ff.data : dec_old_rd;
      inc_new = (inc_fw_ff.en && inc_fw_ff.addr == s2_ff.new_color) ?
                inc_fw_ff.data : inc_new_rd;
      dec_new = (dec_fw_ff.en && dec_fw_ff.addr == s2_ff.new_color) ?
                dec_fw_ff.data : dec_new_rd;

      // The counts wrap, but their difference is the true occupancy.
      hist_old = inc_old - dec_old;
      hist_new = inc_new - dec_new;

      dec_en = s2_ff.active && (s2_old_ff != '0);
      inc_en = s2_ff.active && (s2_ff.new_color != '0);

      // Removing the old color comes first, which matters when it is the new one.
      hist_new_mid = (dec_en && s2_old_ff == s2_ff.new_color) ?
                     hist_new - HIST_W'(1) : hist_new;
      drop = dec_en && (hist_old == HIST_W'(1));
      rise = inc_en && (hist_new_mid == '0);

      total_in = total_ff + TOTAL_W'(rise) - TOTAL_W'(drop);

      if (clearing_ff) begin
         inc_wr.en   = (32'(clr_cnt_ff) < COLOR_COUNT);
         inc_wr.addr = clr_cnt_ff[COLOR_W-1:0];
         inc_wr.data = '0;
         dec_wr      = inc_wr;
      end else begin
         inc_wr.en   = inc_en;
         inc_wr.addr = s2_ff.new_color;
         inc_wr.data = inc_new + HIST_W'(1);
         dec_wr.en   = dec_en;
         dec_wr.addr = s2_old_ff;
         dec_wr.data = dec_old + HIST_W'(1);
      end
   end

   // Result queue.
   always_comb begin
      wr_ptr_in     = wr_ptr_ff + RSP_PTR_W'(s2_ff.valid);
      rd_ptr_in     = rd_ptr_ff + RSP_PTR_W'(rsp_acc);
      fifo_count_in = fifo_count_ff + CREDIT_W'(s2_ff.valid) - CREDIT_W'(rsp_acc);
      credit_in     = credit_ff + CREDIT_W'(req_acc) - CREDIT_W'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clr_cnt_ff    <= '0;
         s1_ff         <= '0;
         s2_ff         <= '0;
         inc_fw_ff     <= '0;
         dec_fw_ff     <= '0;
         total_ff      <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
         credit_ff     <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clr_cnt_ff    <= clr_cnt_in;
         s1_ff         <= s1_in;
         s2_ff         <= s2_in;
         inc_fw_ff     <= inc_wr;
         dec_fw_ff     <= dec_wr;
         total_ff      <= total_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fifo_count_ff <= fifo_count_in;
         credit_ff     <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_old_ff <= s2_old_in;
      if (s2_ff.valid) begin
         fifo_ff[wr_ptr_ff] <= DIST_FIELD_W'(total_in);
      end
   end

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CREDIT_W'(RSP_FIFO_DEPTH))
      else $error("more requests in flight than the result queue can hold");

   a_queue_within_credit: assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff <= credit_ff)
      else $error("result queue holds more entries than outstanding requests");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      s2_ff.valid |-> (fifo_count_ff < CREDIT_W'(RSP_FIFO_DEPTH)) || rsp_acc)
      else $error("result pushed into a full queue");

   a_idle_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_tready && !s1_ff.valid && !s2_ff.valid)
      else $error("request in the pipeline during the clearing pass");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) < COLOR_COUNT)
      else $error("distinct color total exceeds the number of nonzero colors");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      !$past(s2_ff.valid) |-> $stable(total_ff))
      else $error("total changed without a request in the last stage");

endmodule
